>>> sv/rdvb_pkg.sv
// Shared types, constants and helpers for the RTC date check and BCD encoder.
package rdvb_pkg;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_MONTH_DAY = 3'd1;
    localparam logic [2:0] ERR_DAY_RANGE = 3'd2;
    localparam logic [2:0] ERR_TIME      = 3'd3;
    localparam logic [2:0] ERR_YEAR      = 3'd4;

    localparam logic [7:0]  ALARM_ENABLE = 8'h80;
    localparam logic [14:0] YEAR_BASE    = 15'd1900;
    localparam logic [14:0] YEAR_MAX     = 15'd9999;
    localparam logic [4:0]  MONTH_MAX    = 5'd12;
    localparam logic [4:0]  HOUR_LIMIT   = 5'd24;
    localparam logic [5:0]  MIN_LIMIT    = 6'd60;
    localparam logic [4:0]  FEBRUARY     = 5'd2;

    // floor(y / 100) == (y * 5243) >> 19 for every y below 43699
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [7:0]  CENTURY      = 8'd100;

    localparam logic [4:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic        alarm;
        logic [14:0] year;
        logic [4:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  mlen;
        logic        is_feb;
        logic        err_month_day;
        logic        err_time;
        logic        err_year;
    } t_s1;

    typedef struct packed {
        t_s1        s1;
        logic [7:0] q100;
    } t_s2;

    typedef struct packed {
        logic       alarm;
        logic [2:0] err;
        logic [4:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] q100;
        logic [6:0] r100;
    } t_s3;

    // Two-digit BCD of a value below 100; tens = (v * 205) >> 11.
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {8'd0, v} * 15'd205;
        tens = prod[14:11];
        ones = v - 7'({3'd0, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

>>> sv/rdvb_in_if.sv
// Input channel: one broken-down time per transaction.
interface rdvb_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [13:0] year_offset;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;

    modport source (output valid, opcode, year_offset, month_index, day_of_month,
                    hour_value, minute_value, second_value, input ready);
    modport sink   (input valid, opcode, year_offset, month_index, day_of_month,
                    hour_value, minute_value, second_value, output ready);
endinterface

>>> sv/rdvb_out_if.sv
// Output channel: error code and BCD register values per transaction.
interface rdvb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic [7:0]  bcd_second;
    logic [7:0]  bcd_minute;
    logic [7:0]  bcd_hour;
    logic [7:0]  bcd_day;
    logic [7:0]  bcd_month;
    logic [15:0] bcd_year;

    modport source  (output valid, error_code, bcd_second, bcd_minute, bcd_hour,
                     bcd_day, bcd_month, bcd_year, input ready);
    modport sink    (input valid, error_code, bcd_second, bcd_minute, bcd_hour,
                     bcd_day, bcd_month, bcd_year, output ready);
    modport monitor (input valid, ready, error_code, bcd_second, bcd_minute, bcd_hour,
                     bcd_day, bcd_month, bcd_year);
endinterface

>>> sv/rdvb_norm.sv
// Stage 1: form full year and month, run range checks, look up month length.
module rdvb_norm import rdvb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_opcode,
    input  logic [13:0] i_year_offset,
    input  logic [3:0]  i_month_index,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour_value,
    input  logic [5:0]  i_minute_value,
    input  logic [5:0]  i_second_value,
    output t_s1         o_s1
);
    t_s1        r_s1;
    t_s1        n_s1;
    logic [3:0] mon_idx;

    always_comb begin
        n_s1.alarm  = i_opcode;
        n_s1.year   = {1'b0, i_year_offset} + YEAR_BASE;
        n_s1.month  = {1'b0, i_month_index} + 5'd1;
        n_s1.day    = i_day_of_month;
        n_s1.hour   = i_hour_value;
        n_s1.minute = i_minute_value;
        n_s1.second = i_second_value;
        // Out-of-range months read entry zero; they are flagged anyway.
        mon_idx     = (n_s1.month > MONTH_MAX) ? 4'd0 : n_s1.month[3:0];
        n_s1.mlen   = MONTH_LEN[mon_idx];
        n_s1.is_feb = (n_s1.month == FEBRUARY);
        n_s1.err_month_day = (n_s1.month > MONTH_MAX) || (i_day_of_month == 5'd0);
        n_s1.err_time = (i_hour_value >= HOUR_LIMIT) || (i_minute_value >= MIN_LIMIT) ||
                        (i_second_value >= MIN_LIMIT);
        n_s1.err_year = (n_s1.year > YEAR_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;
endmodule

>>> sv/rdvb_div.sv
// Stage 2: year divided by 100 through a reciprocal multiply.
module rdvb_div import rdvb_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_s1  i_s1,
    output t_s2  o_s2
);
    t_s2         r_s2;
    t_s2         n_s2;
    logic [27:0] prod;

    always_comb begin
        prod      = {13'd0, i_s1.year} * {15'd0, DIV100_MUL};
        n_s2.s1   = i_s1;
        n_s2.q100 = prod[DIV100_SHIFT+7:DIV100_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;
endmodule

>>> sv/rdvb_check.sv
// Stage 3: remainder by 100, Gregorian leap rule, day limit, error priority.
module rdvb_check import rdvb_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_s2  i_s2,
    output t_s3  o_s3
);
    t_s3         r_s3;
    t_s3         n_s3;
    logic [14:0] rem;
    logic        leap;
    logic [4:0]  lim;

    always_comb begin
        rem  = i_s2.s1.year - 15'({7'd0, i_s2.q100} * {7'd0, CENTURY});
        // Divisible by 400 means remainder zero and quotient divisible by 4.
        leap = (i_s2.s1.year[1:0] == 2'd0) &&
               ((rem[6:0] != 7'd0) || (i_s2.q100[1:0] == 2'd0));
        lim  = i_s2.s1.mlen + {4'd0, i_s2.s1.is_feb & leap};

        priority if (i_s2.s1.err_month_day) begin
            n_s3.err = ERR_MONTH_DAY;
        end else if (i_s2.s1.day > lim) begin
            n_s3.err = ERR_DAY_RANGE;
        end else if (i_s2.s1.err_time) begin
            n_s3.err = ERR_TIME;
        end else if (i_s2.s1.err_year) begin
            n_s3.err = ERR_YEAR;
        end else begin
            n_s3.err = ERR_OK;
        end

        n_s3.alarm  = i_s2.s1.alarm;
        n_s3.month  = i_s2.s1.month;
        n_s3.day    = i_s2.s1.day;
        n_s3.hour   = i_s2.s1.hour;
        n_s3.minute = i_s2.s1.minute;
        n_s3.second = i_s2.s1.second;
        n_s3.q100   = i_s2.q100[6:0];
        n_s3.r100   = rem[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;
endmodule

>>> sv/rdvb_encode.sv
// Stage 4: BCD conversion, alarm enable bits, zero fill on error; output register.
module rdvb_encode import rdvb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_s3         i_s3,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_bcd_second,
    output logic [7:0]  o_bcd_minute,
    output logic [7:0]  o_bcd_hour,
    output logic [7:0]  o_bcd_day,
    output logic [7:0]  o_bcd_month,
    output logic [15:0] o_bcd_year
);
    logic [2:0]  r_err;
    logic [7:0]  r_sec, r_min, r_hour, r_day, r_mon;
    logic [15:0] r_year;
    logic        ok;
    logic [7:0]  flag;

    always_comb begin
        ok   = (i_s3.err == ERR_OK);
        flag = i_s3.alarm ? ALARM_ENABLE : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err <= i_s3.err;
            if (ok) begin
                r_sec  <= bcd2({1'b0, i_s3.second}) | flag;
                r_min  <= bcd2({1'b0, i_s3.minute}) | flag;
                r_hour <= bcd2({2'd0, i_s3.hour}) | flag;
                r_day  <= bcd2({2'd0, i_s3.day}) | flag;
                r_mon  <= bcd2({2'd0, i_s3.month}) | flag;
                r_year <= {bcd2(i_s3.q100), bcd2(i_s3.r100)};
            end else begin
                r_sec  <= 8'h00;
                r_min  <= 8'h00;
                r_hour <= 8'h00;
                r_day  <= 8'h00;
                r_mon  <= 8'h00;
                r_year <= 16'h0000;
            end
        end
    end

    assign o_error_code = r_err;
    assign o_bcd_second = r_sec;
    assign o_bcd_minute = r_min;
    assign o_bcd_hour   = r_hour;
    assign o_bcd_day    = r_day;
    assign o_bcd_month  = r_mon;
    assign o_bcd_year   = r_year;
endmodule

>>> sv/rtc_date_validate_bcd_encode.sv
// An accepted input transaction reaches its result on o_rsp through the stage registers.
// Throughput: one transaction per cycle while o_rsp.ready holds; four register stages
//   (normalize, divide by 100, check, encode), each advancing on its own enable.
// Backpressure collapses bubbles: a stage loads when it is empty or the next one moves.
// Reset (synchronous, active low) clears the stage valid bits only; data holds garbage.
module rtc_date_validate_bcd_encode import rdvb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rdvb_in_if.sink    i_req,
    rdvb_out_if.source o_rsp
);
    localparam int NSTAGE = 4;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] en;
    t_s1 s1;
    t_s2 s2;
    t_s3 s3;

    // Ready ripples back: a stage can take new data if it is empty or drains this cycle.
    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || o_rsp.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_req.ready = en[0];
    assign o_rsp.valid = r_vld[NSTAGE-1];

    // Advance valid bits alongside the data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Full year, one-based month, range flags and month length.
    rdvb_norm u_norm (
        .i_clk          (i_clk),
        .i_en           (en[0]),
        .i_opcode       (i_req.opcode),
        .i_year_offset  (i_req.year_offset),
        .i_month_index  (i_req.month_index),
        .i_day_of_month (i_req.day_of_month),
        .i_hour_value   (i_req.hour_value),
        .i_minute_value (i_req.minute_value),
        .i_second_value (i_req.second_value),
        .o_s1           (s1)
    );

    // Century quotient for the leap rule and the upper BCD year digits.
    rdvb_div u_div (
        .i_clk (i_clk),
        .i_en  (en[1]),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    // Leap year, day limit, and the first failing check.
    rdvb_check u_check (
        .i_clk (i_clk),
        .i_en  (en[2]),
        .i_s2  (s2),
        .o_s3  (s3)
    );

    // Packed BCD with alarm enable bits; zeroed when any check failed.
    rdvb_encode u_encode (
        .i_clk        (i_clk),
        .i_en         (en[3]),
        .i_s3         (s3),
        .o_error_code (o_rsp.error_code),
        .o_bcd_second (o_rsp.bcd_second),
        .o_bcd_minute (o_rsp.bcd_minute),
        .o_bcd_hour   (o_rsp.bcd_hour),
        .o_bcd_day    (o_rsp.bcd_day),
        .o_bcd_month  (o_rsp.bcd_month),
        .o_bcd_year   (o_rsp.bcd_year)
    );
endmodule

>>> sv/rdvb_checker.sv
// Port-level assertions for the date encoder, bound to the top level.
module rdvb_checker import rdvb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_error_code,
    input logic [7:0]  i_bcd_second,
    input logic [7:0]  i_bcd_minute,
    input logic [7:0]  i_bcd_hour,
    input logic [7:0]  i_bcd_day,
    input logic [7:0]  i_bcd_month,
    input logic [15:0] i_bcd_year
);
    // Hold a result until it is taken.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped before it was taken");

    // Drop all results in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result visible right after reset");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_error_code <= ERR_YEAR))
        else $error("error code out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_error_code != ERR_OK) |->
        (i_bcd_second == 8'h00) && (i_bcd_minute == 8'h00) &&
        (i_bcd_hour == 8'h00) && (i_bcd_day == 8'h00) &&
        (i_bcd_month == 8'h00) && (i_bcd_year == 16'h0000))
        else $error("failed check but nonzero BCD fields");

    a_ok_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_error_code == ERR_OK) |->
        (i_bcd_second[6:4] <= 3'd5) && (i_bcd_second[3:0] <= 4'd9) &&
        (i_bcd_year[15:12] <= 4'd9) && (i_bcd_year[15:12] != 4'd0) &&
        (i_bcd_year[3:0] <= 4'd9) && (i_bcd_month[3:0] <= 4'd9))
        else $error("valid result carries a non-BCD digit");
endmodule

bind rtc_date_validate_bcd_encode rdvb_checker u_rdvb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_rsp.valid),
    .i_ready      (o_rsp.ready),
    .i_error_code (o_rsp.error_code),
    .i_bcd_second (o_rsp.bcd_second),
    .i_bcd_minute (o_rsp.bcd_minute),
    .i_bcd_hour   (o_rsp.bcd_hour),
    .i_bcd_day    (o_rsp.bcd_day),
    .i_bcd_month  (o_rsp.bcd_month),
    .i_bcd_year   (o_rsp.bcd_year)
);

>>> tb/tb_top.sv
// Self-checking testbench for the RTC date check and BCD encoder.
module tb_top;
    import rdvb_pkg::*;

    // Pipeline depth from input transaction to result, and the settle time at the end.
    localparam int LATENCY     = 4;
    localparam int SETTLE      = 4 * LATENCY;
    localparam int RANDOM_ITEMS = 900;
    // Once this few dates remain to be sent, both sides stop idling.
    localparam int TAIL_ITEMS  = 60;
    localparam int CYCLE_LIMIT = 100000;
    localparam int BASE_YEAR   = 1900;
    localparam int LAST_YEAR   = 9999;

    localparam int DAYS_IN_MONTH [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // One broken-down time as it goes onto the request channel.
    typedef struct packed {
        logic        opcode;
        logic [13:0] year_offset;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [4:0]  hour_value;
        logic [5:0]  minute_value;
        logic [5:0]  second_value;
    } date_item_t;

    // A queued date; drain makes the driver wait for every result before sending it.
    typedef struct {
        date_item_t d;
        bit         drain;
    } queued_date_t;

    // Register values that come back on the response channel.
    typedef struct packed {
        logic [2:0]  error_code;
        logic [7:0]  bcd_second;
        logic [7:0]  bcd_minute;
        logic [7:0]  bcd_hour;
        logic [7:0]  bcd_day;
        logic [7:0]  bcd_month;
        logic [15:0] bcd_year;
    } rtc_regs_t;

    logic clk;
    logic rst_n;

    rdvb_in_if  req_if ();
    rdvb_out_if rsp_if ();

    rtc_date_validate_bcd_encode DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    queued_date_t pending_dates [$];
    rtc_regs_t    expected_regs [$];

    date_item_t   on_bus;
    queued_date_t next_date;
    rtc_regs_t    want_regs;
    rtc_regs_t    got_regs;

    int send_gap;
    int stall_left;
    int cycle_count;
    int mismatch_count;
    int sent_count;
    int alarm_count;
    int checked_count;
    int code_tally [0:7];

    // Days in a month of a full Gregorian year; month is one-based.
    function automatic int days_in_month(int year, int month);
        bit leap;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        return DAYS_IN_MONTH[month] + ((month == 2 && leap) ? 1 : 0);
    endfunction

    function automatic logic [7:0] to_bcd2(int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [15:0] to_bcd4(int v);
        return {4'(v / 1000), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    // Work out the registers for one date: the first failing check wins, and a
    // failed date clears every BCD field.
    function automatic rtc_regs_t predict_rtc_regs(date_item_t d);
        rtc_regs_t  r;
        int         year;
        int         month;
        logic [7:0] flag;
        r     = '0;
        year  = int'(d.year_offset) + BASE_YEAR;
        month = int'(d.month_index) + 1;
        flag  = d.opcode ? ALARM_ENABLE : 8'h00;
        if (month > 12 || d.day_of_month == 0) begin
            r.error_code = ERR_MONTH_DAY;
        end else if (int'(d.day_of_month) > days_in_month(year, month)) begin
            r.error_code = ERR_DAY_RANGE;
        end else if (d.hour_value >= 24 || d.minute_value >= 60 || d.second_value >= 60) begin
            r.error_code = ERR_TIME;
        end else if (year > LAST_YEAR) begin
            r.error_code = ERR_YEAR;
        end else begin
            r.error_code = ERR_OK;
            r.bcd_second = to_bcd2(int'(d.second_value)) | flag;
            r.bcd_minute = to_bcd2(int'(d.minute_value)) | flag;
            r.bcd_hour   = to_bcd2(int'(d.hour_value)) | flag;
            r.bcd_day    = to_bcd2(int'(d.day_of_month)) | flag;
            r.bcd_month  = to_bcd2(month) | flag;
            r.bcd_year   = to_bcd4(year);
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got_v, int unsigned want_v);
        $display("tb_top: mismatch in %s on result %0d: got %0h, expected %0h",
                 field, checked_count, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic add_date(bit op, int yoff, int mon, int day, int hr, int mi, int se,
                            bit drain = 1'b0);
        queued_date_t q;
        q.d     = '{op, 14'(yoff), 4'(mon), 5'(day), 5'(hr), 6'(mi), 6'(se)};
        q.drain = drain;
        pending_dates.push_back(q);
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Driver: record each accepted transaction as an expectation, then either
    // idle for a short burst or present the next queued date.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_regs.push_back(predict_rtc_regs(on_bus));
                sent_count++;
                alarm_count += int'(on_bus.opcode);
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_dates.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (pending_dates[0].drain && expected_regs.size() != 0) begin
                    // Hold off until the pipeline has emptied.
                    req_if.valid <= 1'b0;
                end else if (pending_dates.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                    send_gap     = $urandom_range(0, 2);
                    req_if.valid <= 1'b0;
                end else begin
                    next_date = pending_dates.pop_front();
                    on_bus    = next_date.d;
                    req_if.valid        <= 1'b1;
                    req_if.opcode       <= on_bus.opcode;
                    req_if.year_offset  <= on_bus.year_offset;
                    req_if.month_index  <= on_bus.month_index;
                    req_if.day_of_month <= on_bus.day_of_month;
                    req_if.hour_value   <= on_bus.hour_value;
                    req_if.minute_value <= on_bus.minute_value;
                    req_if.second_value <= on_bus.second_value;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation,
    // and stall the response channel in short random bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_regs = '{rsp_if.error_code, rsp_if.bcd_second, rsp_if.bcd_minute,
                             rsp_if.bcd_hour, rsp_if.bcd_day, rsp_if.bcd_month,
                             rsp_if.bcd_year};
                checked_count++;
                if (expected_regs.size() == 0) begin
                    report_mismatch("result with nothing expected", got_regs.error_code, 0);
                end else begin
                    want_regs = expected_regs.pop_front();
                    code_tally[got_regs.error_code]++;
                    if (got_regs.error_code !== want_regs.error_code)
                        report_mismatch("error_code", got_regs.error_code, want_regs.error_code);
                    if (got_regs.bcd_second !== want_regs.bcd_second)
                        report_mismatch("bcd_second", got_regs.bcd_second, want_regs.bcd_second);
                    if (got_regs.bcd_minute !== want_regs.bcd_minute)
                        report_mismatch("bcd_minute", got_regs.bcd_minute, want_regs.bcd_minute);
                    if (got_regs.bcd_hour !== want_regs.bcd_hour)
                        report_mismatch("bcd_hour", got_regs.bcd_hour, want_regs.bcd_hour);
                    if (got_regs.bcd_day !== want_regs.bcd_day)
                        report_mismatch("bcd_day", got_regs.bcd_day, want_regs.bcd_day);
                    if (got_regs.bcd_month !== want_regs.bcd_month)
                        report_mismatch("bcd_month", got_regs.bcd_month, want_regs.bcd_month);
                    if (got_regs.bcd_year !== want_regs.bcd_year)
                        report_mismatch("bcd_year", got_regs.bcd_year, want_regs.bcd_year);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (pending_dates.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                stall_left   = $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        date_item_t   d;
        queued_date_t q;
        int           k;
        int           kind;
        int           mdays;
        // Drive every input to a known value before the first edge.
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.opcode       = 1'b0;
        req_if.year_offset  = '0;
        req_if.month_index  = '0;
        req_if.day_of_month = '0;
        req_if.hour_value   = '0;
        req_if.minute_value = '0;
        req_if.second_value = '0;
        rsp_if.ready        = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        sent_count     = 0;
        alarm_count    = 0;
        checked_count  = 0;
        foreach (code_tally[i]) code_tally[i] = 0;

        // Directed dates: range edges, leap rule, every error and the check order.
        add_date(0, 0, 0, 1, 0, 0, 0);            // earliest date, 1900-01-01
        add_date(1, 8099, 11, 31, 23, 59, 59);    // last valid moment, alarm
        add_date(0, 8100, 0, 1, 0, 0, 0);         // year 10000
        add_date(1, 16383, 15, 31, 31, 63, 63);   // every bit high
        add_date(0, 0, 0, 0, 0, 0, 0);            // every bit low, day zero
        add_date(0, 124, 12, 1, 0, 0, 0);         // month thirteen
        add_date(0, 124, 1, 29, 12, 30, 30);      // leap day, ordinary leap year
        add_date(0, 0, 1, 29, 0, 0, 0);           // 1900 is no leap year
        add_date(1, 100, 1, 29, 0, 0, 0);         // 2000 is a leap year
        add_date(0, 200, 1, 29, 0, 0, 0);         // 2100 is not
        add_date(0, 123, 1, 28, 0, 0, 0);         // last day of a short February
        add_date(0, 123, 3, 31, 0, 0, 0);         // April 31
        add_date(0, 123, 0, 31, 0, 0, 0);         // January 31
        add_date(0, 123, 0, 1, 24, 0, 0);         // hour out of range
        add_date(0, 123, 0, 1, 0, 60, 0);         // minute out of range
        add_date(0, 123, 0, 1, 0, 0, 60);         // second out of range
        add_date(1, 123, 0, 1, 23, 59, 59);       // end of day, alarm
        add_date(0, 123, 12, 0, 31, 63, 63);      // bad month wins over bad time
        add_date(0, 123, 3, 31, 24, 0, 0);        // past month end wins over bad time
        add_date(0, 8100, 0, 1, 24, 0, 0);        // bad time wins over bad year
        add_date(0, 8100, 1, 29, 0, 0, 0);        // year 10000 is leap, so year error
        add_date(0, 8200, 1, 29, 0, 0, 0);        // year 10100 is not leap
        add_date(1, 9, 8, 9, 9, 9, 9);            // a nine in the last digit of every field
        add_date(1, 8099, 1, 28, 0, 0, 0);        // February of the last year

        // Random dates: mostly well formed, some pushed past a limit, some noise.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                d.opcode       = 1'($urandom());
                d.year_offset  = 14'($urandom());
                d.month_index  = 4'($urandom());
                d.day_of_month = 5'($urandom());
                d.hour_value   = 5'($urandom());
                d.minute_value = 6'($urandom());
                d.second_value = 6'($urandom());
            end else begin
                d.opcode       = 1'($urandom());
                d.year_offset  = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(8100, 16383))
                                                             : 14'($urandom_range(0, 8099));
                d.month_index  = 4'($urandom_range(0, 11));
                mdays          = days_in_month(int'(d.year_offset) + BASE_YEAR,
                                               int'(d.month_index) + 1);
                d.day_of_month = (kind == 2 && mdays < 31) ? 5'(mdays + 1)
                                                           : 5'($urandom_range(1, mdays));
                d.hour_value   = 5'($urandom_range(0, 23));
                d.minute_value = 6'($urandom_range(0, 59));
                d.second_value = 6'($urandom_range(0, 59));
                if (kind == 3) begin
                    case ($urandom_range(0, 2))
                        0: d.hour_value   = 5'($urandom_range(24, 31));
                        1: d.minute_value = 6'($urandom_range(60, 63));
                        default: d.second_value = 6'($urandom_range(60, 63));
                    endcase
                end
            end
            q.d     = d;
            // Empty the pipeline before the random part and twice within it.
            q.drain = (k == 0 || k == 300 || k == 600);
            pending_dates.push_back(q);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last transaction to go out and every result to come back.
        while (pending_dates.size() != 0 || req_if.valid || expected_regs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("tb_top: %0d dates sent, %0d of them alarm settings, %0d results checked",
                 sent_count, alarm_count, checked_count);
        $display("tb_top: by code: ok %0d, month/day %0d, past month end %0d, time %0d, year %0d",
                 code_tally[ERR_OK], code_tally[ERR_MONTH_DAY], code_tally[ERR_DAY_RANGE],
                 code_tally[ERR_TIME], code_tally[ERR_YEAR]);
        if (mismatch_count == 0 && expected_regs.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rdvb_pkg.sv
sv/rdvb_in_if.sv
sv/rdvb_out_if.sv
sv/rdvb_norm.sv
sv/rdvb_div.sv
sv/rdvb_check.sv
sv/rdvb_encode.sv
sv/rtc_date_validate_bcd_encode.sv
sv/rdvb_checker.sv
tb/tb_top.sv
